// File: hw/rtl/tgad_pkg.sv
// Shared types and constants for the TGA true-color stream decoder.
// Used by tgad_parser and tga_truecolor_stream_decoder_top; no dependencies.
package tgad_pkg;

    // address space of the destination frame buffer, in pixel index bits
    localparam int ADDR_BITS = 24;

    // largest pixel count that still fits the address space
    localparam logic [32:0] MAX_PIXELS = 33'(1) << ADDR_BITS;

    // header layout
    localparam logic [4:0] HDR_LEN        = 5'd18;
    localparam logic [4:0] POS_ID_LEN     = 5'd0;
    localparam logic [4:0] POS_MAP_TYPE   = 5'd1;
    localparam logic [4:0] POS_IMG_TYPE   = 5'd2;
    localparam logic [4:0] POS_MAP_LEN_LO = 5'd5;
    localparam logic [4:0] POS_MAP_LEN_HI = 5'd6;
    localparam logic [4:0] POS_MAP_BITS   = 5'd7;
    localparam logic [4:0] POS_MAP_MUL    = 5'd8;
    localparam logic [4:0] POS_WIDTH_LO   = 5'd12;
    localparam logic [4:0] POS_WIDTH_HI   = 5'd13;
    localparam logic [4:0] POS_HEIGHT_LO  = 5'd14;
    localparam logic [4:0] POS_HEIGHT_HI  = 5'd15;
    localparam logic [4:0] POS_SIZE_MUL   = 5'd16;
    localparam logic [4:0] POS_DESC       = 5'd17;

    localparam logic [7:0] IMG_TRUECOLOR  = 8'd2;
    localparam logic [7:0] MAP_PRESENT    = 8'd1;
    localparam int         DESC_TOP_DOWN  = 5;
    localparam logic [7:0] OPAQUE_ALPHA   = 8'hff;

    // parser phase, one-hot
    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_SKIP   = 4'b0010,
        PH_PIXEL  = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    // result kind codes
    typedef enum logic [2:0] {
        KIND_PIXEL  = 3'd0,
        KIND_ACCEPT = 3'd1,
        KIND_TYPE   = 3'd2,
        KIND_TRUNC  = 3'd3,
        KIND_LARGE  = 3'd4
    } kind_t;

    // one input byte with its framing flags
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       final_byte;
    } item_t;

    // one result
    typedef struct packed {
        kind_t       kind;
        logic [31:0] pixel_word;
        logic [23:0] pixel_address;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        alpha_present;
        logic        last;
    } res_t;

endpackage

// File: hw/rtl/tga_truecolor_stream_decoder_top.sv
// Top level of the TGA true-color stream decoder: input register, parser, result register.
// Depends on tgad_pkg and tgad_parser.
// a byte's result is offered from the result register, behind the input register and parser
// throughput: one byte per cycle while no result waits on m_axis_tready
// while a result waits on m_axis_tready the input register holds at most one byte, then stalls
// reset (rst_n low, asynchronous) empties both registers and puts the parser in the header phase
module tga_truecolor_stream_decoder_top
    import tgad_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] first_byte
    input  logic        s_axis_tlast,   // final_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // [31:0] pixel_word, [55:32] pixel_address,
                                        // [71:56] image_width, [87:72] image_height,
                                        // [88] alpha_present, [95:89] zero
    output logic [2:0]  m_axis_tuser,   // [2:0] kind
    output logic        m_axis_tlast    // last
);

    logic  in_valid_reg;
    item_t in_item_reg;
    logic  out_valid_reg;
    res_t  out_res_reg;
    logic  go;
    logic  res_valid;
    res_t  res;

    // parser step when a byte is held and the result slot is free or draining
    assign go            = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || go;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.data_byte  <= s_axis_tdata;
            in_item_reg.first_byte <= s_axis_tuser;
            in_item_reg.final_byte <= s_axis_tlast;
        end
    end

    tgad_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (go),
        .item      (in_item_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (go)
            out_valid_reg <= res_valid;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (go && res_valid)
            out_res_reg <= res;
    end

    // result transfer packing
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.kind;
    assign m_axis_tlast  = out_res_reg.last;
    assign m_axis_tdata  = {7'd0, out_res_reg.alpha_present, out_res_reg.image_height,
                            out_res_reg.image_width, out_res_reg.pixel_address,
                            out_res_reg.pixel_word};

endmodule

// File: hw/rtl/tgad_parser.sv
// Byte parser of the TGA decoder: header capture, skip counter, pixel assembly.
// Depends on tgad_pkg for phase, kind, item and result types.
module tgad_parser
    import tgad_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  fire,
    input  item_t item,
    output logic  res_valid,
    output res_t  res
);

    phase_t                 phase_reg, phase_next;
    logic [4:0]             pos_reg, pos_next;
    logic [7:0]             id_len_reg, id_len_next;
    logic [7:0]             map_kind_reg, map_kind_next;
    logic [7:0]             img_kind_reg, img_kind_next;
    logic [15:0]            map_len_reg, map_len_next;
    logic [7:0]             map_bits_reg, map_bits_next;
    logic [15:0]            width_reg, width_next;
    logic [15:0]            height_reg, height_next;
    logic [7:0]             desc_reg, desc_next;
    logic [20:0]            skip_reg, skip_next;
    logic [1:0]             bip_reg, bip_next;
    logic [23:0]            pix_reg, pix_next;
    logic [15:0]            col_reg, col_next;
    logic [15:0]            row_reg, row_next;
    logic [ADDR_BITS-1:0]   row_base_reg, row_base_next;
    logic [23:0]            map_prod_reg, map_prod_next;
    logic [31:0]            total_reg, total_next;

    logic                   has_alpha;
    logic                   complete;
    logic                   final_pixel;
    logic [7:0]             alpha;
    logic [15:0]            col_inc;
    logic [ADDR_BITS-1:0]   pix_addr;
    logic [20:0]            skip_calc;

    // next state and result for the byte at hand
    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        id_len_next   = id_len_reg;
        map_kind_next = map_kind_reg;
        img_kind_next = img_kind_reg;
        map_len_next  = map_len_reg;
        map_bits_next = map_bits_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        desc_next     = desc_reg;
        skip_next     = skip_reg;
        bip_next      = bip_reg;
        pix_next      = pix_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        row_base_next = row_base_reg;
        map_prod_next = map_prod_reg;
        total_next    = total_reg;
        res_valid     = 1'b0;
        res.kind      = KIND_PIXEL;
        res.pixel_word    = '0;
        res.pixel_address = '0;
        res.last      = 1'b0;
        alpha         = OPAQUE_ALPHA;
        complete      = 1'b0;
        final_pixel   = 1'b0;
        col_inc       = '0;
        pix_addr      = '0;
        skip_calc     = '0;

        // restart clears all but the staged header products and makes this byte header byte 0
        if (item.first_byte)
        begin
            phase_next    = PH_HEADER;
            pos_next      = '0;
            id_len_next   = '0;
            map_kind_next = '0;
            img_kind_next = '0;
            map_len_next  = '0;
            map_bits_next = '0;
            width_next    = '0;
            height_next   = '0;
            desc_next     = '0;
            skip_next     = '0;
            bip_next      = '0;
            pix_next      = '0;
            col_next      = '0;
            row_next      = '0;
            row_base_next = '0;
        end

        has_alpha = (desc_next[3:0] != 4'd0);

        unique case (phase_next)
            PH_HEADER:
            begin
                // header field capture and staged products
                case (pos_next)
                    POS_ID_LEN:     id_len_next = item.data_byte;
                    POS_MAP_TYPE:   map_kind_next = item.data_byte;
                    POS_IMG_TYPE:   img_kind_next = item.data_byte;
                    POS_MAP_LEN_LO: map_len_next[7:0] = item.data_byte;
                    POS_MAP_LEN_HI: map_len_next[15:8] = item.data_byte;
                    POS_MAP_BITS:   map_bits_next = item.data_byte;
                    POS_MAP_MUL:    map_prod_next = 24'(map_len_next) * 24'(map_bits_next);
                    POS_WIDTH_LO:   width_next[7:0] = item.data_byte;
                    POS_WIDTH_HI:   width_next[15:8] = item.data_byte;
                    POS_HEIGHT_LO:  height_next[7:0] = item.data_byte;
                    POS_HEIGHT_HI:  height_next[15:8] = item.data_byte;
                    POS_SIZE_MUL:   total_next = 32'(width_next) * 32'(height_next);
                    POS_DESC:       desc_next = item.data_byte;
                    default:        ;
                endcase
                has_alpha = (desc_next[3:0] != 4'd0);
                pos_next  = pos_next + 5'd1;

                if (pos_next == HDR_LEN)
                begin
                    // header complete: verdict, skip length and first row base
                    res_valid = 1'b1;
                    if (img_kind_next != IMG_TRUECOLOR)
                    begin
                        phase_next = PH_DONE;
                        res.kind   = KIND_TYPE;
                        res.last   = 1'b1;
                    end
                    else if ({1'b0, total_reg} > MAX_PIXELS)
                    begin
                        phase_next = PH_DONE;
                        res.kind   = KIND_LARGE;
                        res.last   = 1'b1;
                    end
                    else if (total_reg == 32'd0)
                    begin
                        phase_next = PH_DONE;
                        res.kind   = KIND_ACCEPT;
                        res.last   = 1'b1;
                    end
                    else
                    begin
                        bip_next = '0;
                        pix_next = '0;
                        col_next = '0;
                        row_next = '0;
                        if (desc_next[DESC_TOP_DOWN])
                            row_base_next = '0;
                        else
                            row_base_next = ADDR_BITS'(total_reg - 32'(width_next));
                        skip_calc = 21'(id_len_next);
                        if (map_kind_next == MAP_PRESENT)
                            skip_calc = 21'({1'b0, skip_calc} + 22'(map_prod_next[23:3]));
                        skip_next  = skip_calc;
                        phase_next = (skip_calc != 21'd0) ? PH_SKIP : PH_PIXEL;
                        if (item.final_byte)
                        begin
                            phase_next = PH_DONE;
                            res.kind   = KIND_TRUNC;
                            res.last   = 1'b1;
                        end
                        else
                        begin
                            res.kind = KIND_ACCEPT;
                        end
                    end
                end
                else if (item.final_byte)
                begin
                    phase_next = PH_DONE;
                    res_valid  = 1'b1;
                    res.kind   = KIND_TRUNC;
                    res.last   = 1'b1;
                end
            end

            PH_SKIP:
            begin
                // image id and color map bytes are dropped
                skip_next = skip_next - 21'd1;
                if (skip_next == 21'd0)
                    phase_next = PH_PIXEL;
                if (item.final_byte)
                begin
                    phase_next = PH_DONE;
                    res_valid  = 1'b1;
                    res.kind   = KIND_TRUNC;
                    res.last   = 1'b1;
                end
            end

            PH_PIXEL:
            begin
                // byte lanes of the pixel being assembled
                case (bip_next)
                    2'd0:    pix_next = {16'd0, item.data_byte};
                    2'd1:    pix_next[15:8] = item.data_byte;
                    2'd2:    pix_next[23:16] = item.data_byte;
                    default: alpha = item.data_byte;
                endcase
                complete = (bip_next == 2'd3) || (bip_next == 2'd2 && !has_alpha);

                if (!complete)
                begin
                    bip_next = bip_next + 2'd1;
                    if (item.final_byte)
                    begin
                        phase_next = PH_DONE;
                        res_valid  = 1'b1;
                        res.kind   = KIND_TRUNC;
                        res.last   = 1'b1;
                    end
                end
                else
                begin
                    // pixel out, then column and row bookkeeping
                    bip_next    = '0;
                    pix_addr    = ADDR_BITS'(row_base_next + ADDR_BITS'(col_next));
                    final_pixel = ({1'b0, col_next} + 17'd1 == {1'b0, width_next}) &&
                                  ({1'b0, row_next} + 17'd1 == {1'b0, height_next});
                    col_inc     = col_next + 16'd1;
                    col_next    = col_inc;
                    if (col_inc == width_next)
                    begin
                        col_next = '0;
                        row_next = row_next + 16'd1;
                        if (desc_next[DESC_TOP_DOWN])
                            row_base_next = ADDR_BITS'(row_base_next + ADDR_BITS'(width_next));
                        else
                            row_base_next = ADDR_BITS'(row_base_next - ADDR_BITS'(width_next));
                    end

                    res_valid = 1'b1;
                    if (final_pixel)
                    begin
                        phase_next        = PH_DONE;
                        res.kind          = KIND_PIXEL;
                        res.pixel_word    = {alpha, pix_next};
                        res.pixel_address = 24'(pix_addr);
                        res.last          = 1'b1;
                    end
                    else if (item.final_byte)
                    begin
                        phase_next = PH_DONE;
                        res.kind   = KIND_TRUNC;
                        res.last   = 1'b1;
                    end
                    else
                    begin
                        res.kind          = KIND_PIXEL;
                        res.pixel_word    = {alpha, pix_next};
                        res.pixel_address = 24'(pix_addr);
                    end
                end
            end

            PH_DONE:
            begin
                // file ended: bytes dropped until the next first byte
            end

            default:
            begin
                phase_next = PH_HEADER;
            end
        endcase

        res.image_width   = width_next;
        res.image_height  = height_next;
        res.alpha_present = has_alpha;
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            pos_reg      <= '0;
            id_len_reg   <= '0;
            map_kind_reg <= '0;
            img_kind_reg <= '0;
            map_len_reg  <= '0;
            map_bits_reg <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
            desc_reg     <= '0;
            skip_reg     <= '0;
            bip_reg      <= '0;
            pix_reg      <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            row_base_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            id_len_reg   <= id_len_next;
            map_kind_reg <= map_kind_next;
            img_kind_reg <= img_kind_next;
            map_len_reg  <= map_len_next;
            map_bits_reg <= map_bits_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            desc_reg     <= desc_next;
            skip_reg     <= skip_next;
            bip_reg      <= bip_next;
            pix_reg      <= pix_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            row_base_reg <= row_base_next;
        end
    end

    // staged header products
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            map_prod_reg <= map_prod_next;
            total_reg    <= total_next;
        end
    end

    // the final result of a file always leaves the parser finished
    a_last_ends_file: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res_valid && res.last |=> phase_reg == PH_DONE)
        else $error("last result without finished phase");

    // skip phase only with bytes left to drop
    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SKIP |-> skip_reg != 21'd0)
        else $error("skip phase with empty count");

    // a fourth pixel byte only when alpha is read
    a_alpha_lane: assert property (@(posedge clk) disable iff (!rst_n)
        bip_reg == 2'd3 |-> desc_reg[3:0] != 4'd0)
        else $error("alpha lane without alpha");

endmodule
